// File: rtl/sspf_pkg.sv
// Shared types and constants of the sprite sheet pixel fetch block.
// Used by the divider and the top level; depends on nothing.
package sspf_pkg;

    // Item kinds on the request channel
    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0]
    {
        REG_PIXEL_BITS_LOG2 = 2'd0,
        REG_TILE_WIDTH      = 2'd1,
        REG_TILE_HEIGHT     = 2'd2,
        REG_SHEET_COLUMNS   = 2'd3
    } cfg_reg_t;

    typedef struct packed
    {
        op_t         opcode;
        logic [11:0] store_address;
        logic [7:0]  store_byte;
        logic [15:0] tile_index;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        mirror_x;
        logic        mirror_y;
    } req_t;

    typedef struct packed
    {
        logic [7:0] pixel_value;
        logic       address_overflow;
    } rsp_t;

    // Pipelined divider geometry: two quotient bits per stage
    localparam int DIVIDEND_W = 16;
    localparam int DIVISOR_W  = 8;
    localparam int DIV_STAGES = DIVIDEND_W / 2;

endpackage

// File: rtl/sprite_sheet_pixel_fetch_core.sv
// Top level of the sprite sheet pixel fetch block: request pipeline, sheet store, result register.
// Depends on sspf_pkg, sspf_div and sspf_ram.
//
//   channel  handshake              payload                  direction
//   req      req_valid / req_stall  req (sspf_pkg::req_t)    into block
//   rsp      rsp_valid / rsp_stall  rsp (sspf_pkg::rsp_t)    out of block
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data      into block
//
// One item is accepted per clock while req_stall is low. A fetch item passes
// 8 divider stages (two quotient bits each), 4 address stages, the registered
// store read and the result register before its rsp handshake. Write items
// walk the same stages and update the store at the read stage, so program
// order between writes and fetches holds. rst_n clears valid bits and loads
// register defaults; store contents are undefined until written. The whole
// pipeline holds while a result waits under rsp_stall, so req_stall follows it.
module sprite_sheet_pixel_fetch_core #(
    parameter int STORE_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               req_valid,
    output logic               req_stall,
    input  sspf_pkg::req_t     req,

    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sspf_pkg::rsp_t     rsp,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  sspf_pkg::cfg_reg_t cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int SUM_W  = 41;                     // full byte address width
    localparam int DS     = sspf_pkg::DIV_STAGES;

    // Side data that rides beside the divider stages
    typedef struct packed
    {
        sspf_pkg::op_t opcode;
        logic [11:0]   store_address;
        logic [7:0]    store_byte;
        logic          mirror_x;
        logic          mirror_y;
    } meta_t;

    // Side data of the address stages; sub is the pixel slot inside its byte
    typedef struct packed
    {
        sspf_pkg::op_t opcode;
        logic [11:0]   store_address;
        logic [7:0]    store_byte;
        logic [2:0]    sub;
    } ctl_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] pixel_bits_log2_reg;
    logic [7:0] tile_width_reg;
    logic [7:0] tile_height_reg;
    logic [7:0] sheet_columns_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bits_log2_reg <= 2'd2;
            tile_width_reg      <= 8'd16;
            tile_height_reg     <= 8'd16;
            sheet_columns_reg   <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sspf_pkg::REG_PIXEL_BITS_LOG2: pixel_bits_log2_reg <= cfg_data[1:0];
                sspf_pkg::REG_TILE_WIDTH:      tile_width_reg      <= cfg_data;
                sspf_pkg::REG_TILE_HEIGHT:     tile_height_reg     <= cfg_data;
                sspf_pkg::REG_SHEET_COLUMNS:   sheet_columns_reg   <= cfg_data;
            endcase
        end
    end

    // A size of zero counts as one
    logic [7:0] tw;
    logic [7:0] th;
    logic [7:0] cols;
    logic [1:0] shift_ppb;      // log2 of pixels per byte

    assign tw        = (tile_width_reg == 8'd0) ? 8'd1 : tile_width_reg;
    assign th        = (tile_height_reg == 8'd0) ? 8'd1 : tile_height_reg;
    assign cols      = (sheet_columns_reg == 8'd0) ? 8'd1 : sheet_columns_reg;
    assign shift_ppb = 2'd3 - pixel_bits_log2_reg;

    function automatic logic [7:0] field_mask(input logic [1:0] lg);
        logic [7:0] m;
        case (lg)
            2'd0:    m = 8'h01;
            2'd1:    m = 8'h03;
            2'd2:    m = 8'h0f;
            default: m = 8'hff;
        endcase
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Flow control: every stage advances together unless a result is stuck
    // ------------------------------------------------------------------
    logic adv;
    logic rsp_valid_reg;

    assign adv       = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !adv;

    // ------------------------------------------------------------------
    // Divider stages: x mod width, y mod height, sprite row and column
    // ------------------------------------------------------------------
    logic [DS-1:0] dvld_reg;
    meta_t         meta_reg [DS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= '0;
        end
        else if (adv)
        begin
            dvld_reg <= {dvld_reg[DS-2:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= '{opcode:        req.opcode,
                             store_address: req.store_address,
                             store_byte:    req.store_byte,
                             mirror_x:      req.mirror_x,
                             mirror_y:      req.mirror_y};
            for (int i = 1; i < DS; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    logic [7:0]  x_rem;
    logic [7:0]  y_rem;
    logic [15:0] tile_row;
    logic [7:0]  tile_col;

    sspf_div u_div_x (
        .clk       (clk),
        .en        (adv),
        .dividend  (req.pos_x),
        .divisor   (tw),
        .quotient  (),
        .remainder (x_rem)
    );

    sspf_div u_div_y (
        .clk       (clk),
        .en        (adv),
        .dividend  (req.pos_y),
        .divisor   (th),
        .quotient  (),
        .remainder (y_rem)
    );

    sspf_div u_div_tile (
        .clk       (clk),
        .en        (adv),
        .dividend  (req.tile_index),
        .divisor   (cols),
        .quotient  (tile_row),
        .remainder (tile_col)
    );

    // Valid bits of the address stages and the read stage
    logic [4:0] pvld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= '0;
        end
        else if (adv)
        begin
            pvld_reg <= {pvld_reg[3:0], dvld_reg[DS-1]};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: mirror, scale the sprite row, bytes per sheet row, column and x byte offsets
    // ------------------------------------------------------------------
    logic [7:0]  x_mir;
    logic [7:0]  y_mir;
    logic [15:0] row_span;
    logic [15:0] col_span;
    ctl_t        ctl1_next;

    logic [23:0] trow_th1_reg;
    logic [7:0]  y1_reg;
    logic [15:0] row_bytes1_reg;
    logic [15:0] col_bytes1_reg;
    logic [7:0]  x_bytes1_reg;
    ctl_t        ctl1_reg;

    always_comb
    begin
        x_mir = meta_reg[DS-1].mirror_x ? 8'(tw - 8'd1 - x_rem) : x_rem;
        y_mir = meta_reg[DS-1].mirror_y ? 8'(th - 8'd1 - y_rem) : y_rem;
        row_span = 16'(cols) * 16'(tw);
        col_span = 16'(tile_col) * 16'(tw);
        ctl1_next.opcode        = meta_reg[DS-1].opcode;
        ctl1_next.store_address = meta_reg[DS-1].store_address;
        ctl1_next.store_byte    = meta_reg[DS-1].store_byte;
        ctl1_next.sub           = x_mir[2:0] & (3'b111 >> pixel_bits_log2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trow_th1_reg   <= 24'(tile_row) * 24'(th);
            y1_reg         <= y_mir;
            row_bytes1_reg <= row_span >> shift_ppb;
            col_bytes1_reg <= col_span >> shift_ppb;
            x_bytes1_reg   <= x_mir >> shift_ppb;
            ctl1_reg       <= ctl1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sheet line index and byte offset inside the line
    // ------------------------------------------------------------------
    logic [23:0] line2_reg;
    logic [15:0] row_bytes2_reg;
    logic [16:0] off2_reg;
    ctl_t        ctl2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line2_reg      <= trow_th1_reg + 24'(y1_reg);
            row_bytes2_reg <= row_bytes1_reg;
            off2_reg       <= 17'(col_bytes1_reg) + 17'(x_bytes1_reg);
            ctl2_reg       <= ctl1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: line index times bytes per line
    // ------------------------------------------------------------------
    logic [39:0] prod3_reg;
    logic [16:0] off3_reg;
    ctl_t        ctl3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod3_reg <= 40'(line2_reg) * 40'(row_bytes2_reg);
            off3_reg  <= off2_reg;
            ctl3_reg  <= ctl2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final byte address, range check, pick the store access
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  byte_addr;
    logic [SUM_W-1:0]  wr_addr;
    logic [ADDR_W-1:0] ram_addr_next;
    logic              ram_we_next;
    logic              ovf_next;

    logic [ADDR_W-1:0] ram_addr_reg;
    logic              ram_we_reg;
    logic              ovf4_reg;
    ctl_t              ctl4_reg;

    always_comb
    begin
        byte_addr = SUM_W'(prod3_reg) + SUM_W'(off3_reg);
        wr_addr   = SUM_W'(ctl3_reg.store_address);
        if (ctl3_reg.opcode == sspf_pkg::OP_FETCH)
        begin
            ram_addr_next = byte_addr[ADDR_W-1:0];
            ram_we_next   = 1'b0;
            ovf_next      = (byte_addr >= SUM_W'(STORE_BYTES));
        end
        else
        begin
            // drop writes beyond the store
            ram_addr_next = wr_addr[ADDR_W-1:0];
            ram_we_next   = pvld_reg[2] && (wr_addr < SUM_W'(STORE_BYTES));
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_we_reg <= 1'b0;
        end
        else if (adv)
        begin
            ram_we_reg <= ram_we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ram_addr_reg <= ram_addr_next;
            ovf4_reg     <= ovf_next;
            ctl4_reg     <= ctl3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: sheet store access, one item per cycle while the pipeline is not held
    // ------------------------------------------------------------------
    logic [7:0] ram_rdata;
    logic       ovf5_reg;
    ctl_t       ctl5_reg;

    sspf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .en    (adv),
        .we    (ram_we_reg),
        .addr  (ram_addr_reg),
        .wdata (ctl4_reg.store_byte),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ovf5_reg <= ovf4_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: pixel extraction into the result register
    // ------------------------------------------------------------------
    logic [2:0]     pix_shift;
    logic [7:0]     pix;
    sspf_pkg::rsp_t rsp_next;
    sspf_pkg::rsp_t rsp_reg;

    always_comb
    begin
        pix_shift = 3'(ctl5_reg.sub << pixel_bits_log2_reg);
        pix       = (ram_rdata >> pix_shift) & field_mask(pixel_bits_log2_reg);
        rsp_next.pixel_value      = ovf5_reg ? 8'd0 : pix;
        rsp_next.address_overflow = ovf5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            // write items leave the pipeline here without a result
            rsp_valid_reg <= pvld_reg[4] && (ctl5_reg.opcode == sspf_pkg::OP_FETCH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && pvld_reg[4] && ctl5_reg.opcode == sspf_pkg::OP_WRITE) |=> !rsp_valid_reg)
        else $error("write item produced a result");

    a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && pvld_reg[4] && ctl5_reg.opcode == sspf_pkg::OP_FETCH) |=> rsp_valid_reg)
        else $error("fetch item lost before the result register");

    a_store_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we_reg |-> (SUM_W'(ram_addr_reg) < SUM_W'(STORE_BYTES)))
        else $error("store write beyond its depth");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.address_overflow) |-> (rsp_reg.pixel_value == 8'd0))
        else $error("overflowed fetch returned a nonzero pixel");

endmodule

// File: rtl/sspf_div.sv
// Pipelined restoring divider, 16-bit dividend by 8-bit nonzero divisor.
// Depends on sspf_pkg for widths and stage count.
module sspf_div (
    input  logic                                clk,
    input  logic                                en,
    input  logic [sspf_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [sspf_pkg::DIVISOR_W-1:0]      divisor,
    output logic [sspf_pkg::DIVIDEND_W-1:0]     quotient,
    output logic [sspf_pkg::DIVISOR_W-1:0]      remainder
);

    localparam int NW = sspf_pkg::DIVIDEND_W;
    localparam int MW = sspf_pkg::DIVISOR_W;
    localparam int NS = sspf_pkg::DIV_STAGES;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [MW+NW-1:0] div_step(
        input logic [MW-1:0] r,
        input logic [NW-1:0] q,
        input logic [MW-1:0] d
    );
        logic [MW:0]   t;
        logic [MW-1:0] rn;
        logic          qb;
        t = {r, q[NW-1]};
        if (t >= {1'b0, d})
        begin
            rn = MW'(t - {1'b0, d});
            qb = 1'b1;
        end
        else
        begin
            rn = t[MW-1:0];
            qb = 1'b0;
        end
        return {rn, q[NW-2:0], qb};
    endfunction

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [NW-1:0] q_in;
        logic [NW-1:0] q_mid;
        logic [NW-1:0] q_next;
        logic [MW-1:0] r_in;
        logic [MW-1:0] r_mid;
        logic [MW-1:0] r_next;
        logic [NW-1:0] q_reg;
        logic [MW-1:0] r_reg;

        if (s == 0)
        begin : g_first
            assign q_in = dividend;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign q_in = g_stage[s-1].q_reg;
            assign r_in = g_stage[s-1].r_reg;
        end

        assign {r_mid, q_mid}   = div_step(r_in, q_in, divisor);
        assign {r_next, q_next} = div_step(r_mid, q_mid, divisor);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg <= q_next;
                r_reg <= r_next;
            end
        end
    end

    assign quotient  = g_stage[NS-1].q_reg;
    assign remainder = g_stage[NS-1].r_reg;

endmodule

// File: rtl/sspf_ram.sv
// Generic single-port RAM with enable and registered read data.
// Standalone; no package needed.
module sspf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
